### rtl/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
package lfu_pkg;

    // Index and rank fields are sized for the largest supported store (256)
    localparam int IDX_W  = 8;
    localparam int FILL_W = 9;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int USES_W = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [FILL_W-1:0] fill_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [DATA_W-1:0] data_t;
    typedef logic [USES_W-1:0] uses_t;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam uses_t USES_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    // Running summary handed from cell to cell along the chain
    typedef struct packed {
        logic  found;
        idx_t  found_idx;
        idx_t  found_rec;
        data_t found_data;
        logic  free;
        idx_t  free_idx;
        logic  victim;
        idx_t  victim_idx;
        uses_t victim_uses;
        idx_t  victim_rec;
        fill_t fill;
    } scan_t;

    // Update broadcast to every cell at the end of an access
    typedef struct packed {
        logic  en;
        idx_t  idx;
        idx_t  rec_ref;
        logic  all_age;
        logic  set_valid;
        logic  wr_key;
        logic  wr_data;
        logic  set_one;
        logic  inc;
        key_t  key;
        data_t data;
    } upd_t;

endpackage

### rtl/lfu_cell.sv
// One cache entry plus its stage of the lookup / victim search chain.
module lfu_cell #(
    parameter int IDX = 0,
    parameter int RW  = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lfu_pkg::key_t       lookup_key,
    input  lfu_pkg::upd_t       upd,
    input  lfu_pkg::scan_t      scan_in,
    output lfu_pkg::scan_t      scan_out
);

    logic               valid_reg;
    lfu_pkg::key_t      key_reg;
    lfu_pkg::data_t     data_reg;
    lfu_pkg::uses_t     uses_reg;
    logic [RW-1:0]      rec_reg;

    lfu_pkg::scan_t     scan_reg;
    lfu_pkg::scan_t     scan_next;
    lfu_pkg::idx_t      my_idx;
    lfu_pkg::idx_t      rec_ext;
    logic               self_sel;

    assign my_idx   = lfu_pkg::idx_t'(IDX);
    assign rec_ext  = lfu_pkg::idx_t'(rec_reg);
    assign self_sel = upd.en && (upd.idx == my_idx);
    assign scan_out = scan_reg;

    // Fold this entry into the running summary
    always_comb
    begin
        scan_next = scan_in;
        if (valid_reg)
        begin
            scan_next.fill = scan_in.fill + lfu_pkg::fill_t'(1);
            if (key_reg == lookup_key)
            begin
                scan_next.found      = 1'b1;
                scan_next.found_idx  = my_idx;
                scan_next.found_rec  = rec_ext;
                scan_next.found_data = data_reg;
            end
            if (!scan_in.victim || (uses_reg < scan_in.victim_uses) ||
                ((uses_reg == scan_in.victim_uses) && (rec_ext > scan_in.victim_rec)))
            begin
                scan_next.victim      = 1'b1;
                scan_next.victim_idx  = my_idx;
                scan_next.victim_uses = uses_reg;
                scan_next.victim_rec  = rec_ext;
            end
        end
        else if (!scan_in.free)
        begin
            scan_next.free     = 1'b1;
            scan_next.free_idx = my_idx;
        end
    end

    // Chain stage register
    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    // Valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (self_sel && upd.set_valid)
            valid_reg <= 1'b1;
    end

    // Entry payload and recency rank
    always_ff @(posedge clk)
    begin
        if (self_sel)
        begin
            if (upd.wr_key)
                key_reg <= upd.key;
            if (upd.wr_data)
                data_reg <= upd.data;
            if (upd.set_one)
                uses_reg <= lfu_pkg::uses_t'(1);
            else if (upd.inc && (uses_reg != lfu_pkg::USES_MAX))
                uses_reg <= uses_reg + lfu_pkg::uses_t'(1);
            rec_reg <= '0;
        end
        else if (upd.en && valid_reg && (upd.all_age || (rec_ext < upd.rec_ref)))
        begin
            rec_reg <= rec_reg + RW'(1);
        end
    end

endmodule

### rtl/lfu_cache_lru_tiebreak.sv
// Top level: LFU key-value cache with LRU tie-break built as a chain of entry cells.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------
//  input    | in_valid / in_stall   | command, key, value
//  output   | out_valid / out_stall | hit, read_value
//  config   | capacity_we           | capacity_wdata
//
// An item runs from its transfer through the scan (the search summary ripples
// through the cell chain, one cell per cycle, then settles) to the apply step,
// which applies the update and loads the result register; the next item can
// be transferred once the sequencer is back in idle.
// Reset clears all valid bits at once; no clearing pass is needed.
// A held result waits in the output register; the next item is taken meanwhile
// and its scan waits at the end until the result register frees.
module lfu_cache_lru_tiebreak #(
    parameter int ENTRIES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        command,
    input  logic [31:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        hit,
    output logic [31:0] read_value,
    input  logic        capacity_we,
    input  logic [4:0]  capacity_wdata
);

    localparam int RW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNTW = $clog2(ENTRIES + 1);

    lfu_pkg::state_t    state_reg, state_next;
    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [4:0]         capacity_reg;
    logic               cmd_reg;
    lfu_pkg::key_t      key_reg;
    lfu_pkg::data_t     value_reg;
    logic               out_valid_reg;
    logic               hit_reg;
    lfu_pkg::data_t     rdata_reg;

    lfu_pkg::scan_t     chain [0:ENTRIES];
    lfu_pkg::scan_t     tail;
    lfu_pkg::upd_t      upd;
    lfu_pkg::fill_t     cap_eff;
    lfu_pkg::fill_t     cap_ext;
    logic               in_xfer;
    logic               out_xfer;
    logic               out_free;
    logic               load_out;

    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign read_value = rdata_reg;
    assign in_stall  = (state_reg != lfu_pkg::ST_IDLE);

    assign cap_ext = lfu_pkg::fill_t'(capacity_reg);
    assign cap_eff = (cap_ext > lfu_pkg::fill_t'(ENTRIES)) ? lfu_pkg::fill_t'(ENTRIES) : cap_ext;

    // Cell chain
    assign chain[0] = '0;
    assign tail     = chain[ENTRIES];

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        lfu_cell #(
            .IDX (g),
            .RW  (RW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .lookup_key (key_reg),
            .upd        (upd),
            .scan_in    (chain[g]),
            .scan_out   (chain[g+1])
        );
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lfu_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            lfu_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = lfu_pkg::ST_SCAN;
                    cnt_next   = '0;
                end
            end
            lfu_pkg::ST_SCAN:
            begin
                if (cnt_reg != CNTW'(ENTRIES))
                    cnt_next = cnt_reg + CNTW'(1);
                else if (out_free)
                    state_next = lfu_pkg::ST_APPLY;
            end
            lfu_pkg::ST_APPLY:
            begin
                load_out   = 1'b1;
                state_next = lfu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lfu_pkg::ST_IDLE;
            end
        endcase
    end

    // Update decision from the chain summary
    always_comb
    begin
        upd      = '0;
        upd.key  = key_reg;
        upd.data = value_reg;
        if (state_reg == lfu_pkg::ST_APPLY)
        begin
            if (cmd_reg == lfu_pkg::CMD_GET)
            begin
                if (tail.found)
                begin
                    upd.en      = 1'b1;
                    upd.idx     = tail.found_idx;
                    upd.rec_ref = tail.found_rec;
                    upd.inc     = 1'b1;
                end
            end
            else if (cap_eff != '0)
            begin
                priority if (tail.found)
                begin
                    upd.en      = 1'b1;
                    upd.idx     = tail.found_idx;
                    upd.rec_ref = tail.found_rec;
                    upd.inc     = 1'b1;
                    upd.wr_data = 1'b1;
                end
                else if (tail.fill >= cap_eff)
                begin
                    upd.en      = tail.victim;
                    upd.idx     = tail.victim_idx;
                    upd.rec_ref = tail.victim_rec;
                    upd.wr_key  = 1'b1;
                    upd.wr_data = 1'b1;
                    upd.set_one = 1'b1;
                end
                else
                begin
                    upd.en        = tail.free;
                    upd.idx       = tail.free_idx;
                    upd.all_age   = 1'b1;
                    upd.set_valid = 1'b1;
                    upd.wr_key    = 1'b1;
                    upd.wr_data   = 1'b1;
                    upd.set_one   = 1'b1;
                end
            end
        end
    end

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            capacity_reg <= 5'd16;
        else if (capacity_we)
            capacity_reg <= capacity_wdata;
    end

    // Captured request
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            value_reg <= value;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_xfer)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            hit_reg   <= tail.found;
            rdata_reg <= (cmd_reg == lfu_pkg::CMD_GET && tail.found) ? tail.found_data : '0;
        end
    end

    // Checks
    a_rise_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == lfu_pkg::ST_APPLY))
        else $error("result appeared outside the apply step");

    a_upd_only_apply: assert property (@(posedge clk) disable iff (!rst_n)
        upd.en |-> (state_reg == lfu_pkg::ST_APPLY))
        else $error("entry update outside the apply step");

    a_xfer_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == lfu_pkg::ST_SCAN) && (cnt_reg == '0))
        else $error("accepted item did not start a scan");

    a_apply_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lfu_pkg::ST_APPLY) |-> $past(out_free))
        else $error("result register overwritten while held");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the LFU cache with LRU tie-break.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 16;
    localparam int SETTLE     = 40;
    localparam int CYCLE_CAP  = 900000;
    localparam int HOLD_LEN   = 300;

    localparam logic OP_GET = lfu_pkg::CMD_GET;
    localparam logic OP_PUT = lfu_pkg::CMD_PUT;

    typedef struct {
        logic           hit;
        lfu_pkg::data_t rdata;
    } reply_t;

    typedef struct {
        logic           cmd;
        lfu_pkg::key_t  k;
        lfu_pkg::data_t v;
        bit             typed;
        reply_t         want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        command;
    logic [31:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_stall;
    logic        hit;
    logic [31:0] read_value;
    logic        capacity_we;
    logic [4:0]  capacity_wdata;

    lfu_cache_lru_tiebreak dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .command        (command),
        .key            (key),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .read_value     (read_value),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata)
    );

    // Shadow copy of the store
    bit             sh_valid [SLOTS];
    lfu_pkg::key_t  sh_key   [SLOTS];
    lfu_pkg::data_t sh_data  [SLOTS];
    lfu_pkg::uses_t sh_uses  [SLOTS];
    int             sh_rank  [SLOTS];
    int             sh_capacity;

    reply_t        pending_replies[$];
    stim_row_t     directed_rows[$];
    int            fail_count;
    bit            quiet;
    bit            hold_req;
    lfu_pkg::key_t key_pool[$];

    // Make slot s the most recent entry
    function automatic void promote(int s);
        for (int j = 0; j < SLOTS; j++)
            if (sh_valid[j] && j != s && sh_rank[j] < sh_rank[s])
                sh_rank[j]++;
        sh_rank[s] = 0;
    endfunction

    // Expected reply for one access, updating the shadow store
    function automatic reply_t cache_access(logic cmd, lfu_pkg::key_t k, lfu_pkg::data_t v);
        reply_t r;
        int     found;
        int     free_slot;
        int     victim;
        int     fill;
        int     cap;
        found = -1;
        free_slot = -1;
        victim = -1;
        fill = 0;
        cap = (sh_capacity > SLOTS) ? SLOTS : sh_capacity;
        for (int i = 0; i < SLOTS; i++) begin
            if (sh_valid[i]) begin
                fill++;
                if (sh_key[i] == k)
                    found = i;
                if (victim < 0 || sh_uses[i] < sh_uses[victim] ||
                    (sh_uses[i] == sh_uses[victim] && sh_rank[i] > sh_rank[victim]))
                    victim = i;
            end
            else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        r.hit = (found >= 0);
        r.rdata = '0;
        if (cmd == OP_GET) begin
            if (found >= 0) begin
                r.rdata = sh_data[found];
                if (sh_uses[found] != lfu_pkg::USES_MAX)
                    sh_uses[found]++;
                promote(found);
            end
        end
        else if (cap != 0) begin
            if (found >= 0) begin
                sh_data[found] = v;
                if (sh_uses[found] != lfu_pkg::USES_MAX)
                    sh_uses[found]++;
                promote(found);
            end
            else if (fill >= cap) begin
                sh_key[victim] = k;
                sh_data[victim] = v;
                sh_uses[victim] = 1;
                promote(victim);
            end
            else begin
                for (int i = 0; i < SLOTS; i++)
                    if (sh_valid[i])
                        sh_rank[i]++;
                sh_valid[free_slot] = 1'b1;
                sh_key[free_slot] = k;
                sh_data[free_slot] = v;
                sh_uses[free_slot] = 1;
                sh_rank[free_slot] = 0;
            end
        end
        return r;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (quiet || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one access and wait for the transfer
    task automatic send_access(logic cmd, lfu_pkg::key_t k, lfu_pkg::data_t v, bit typed,
                               reply_t want);
        int     gap;
        reply_t r;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = cache_access(cmd, k, v);
        pending_replies.push_back(typed ? want : r);
    endtask

    // Capacity is written only once the cache has drained
    task automatic set_capacity(logic [4:0] c);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        capacity_we    <= 1'b1;
        capacity_wdata <= c;
        @(posedge clk);
        capacity_we    <= 1'b0;
        sh_capacity = int'(c);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Cycle limit
    initial
    begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Receiver back-pressure, with one long hold when requested
    initial
    begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else begin
                out_stall <= (!quiet && $urandom_range(99) < 25);
                if (!quiet && $urandom_range(199) == 0) begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(40, 10)) @(posedge clk);
                end
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        reply_t w;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected transfer hit=%0b read_value=%h",
                         $time, hit, read_value);
                fail_count++;
            end
            else begin
                w = pending_replies.pop_front();
                if (hit !== w.hit) begin
                    $display("%0t: hit expected %0b actual %0b", $time, w.hit, hit);
                    fail_count++;
                end
                if (read_value !== w.rdata) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, w.rdata, read_value);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        stim_row_t     row;
        reply_t        none;
        logic [4:0]    caps[8];
        int            n_items;
        logic          cmd;
        lfu_pkg::key_t k;

        fail_count = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = OP_GET;
        key = '0;
        value = '0;
        capacity_we = 1'b0;
        capacity_wdata = '0;
        none.hit = 1'b0;
        none.rdata = '0;
        for (int i = 0; i < SLOTS; i++) begin
            sh_valid[i] = 1'b0;
            sh_key[i] = '0;
            sh_data[i] = '0;
            sh_uses[i] = '0;
            sh_rank[i] = 0;
        end
        sh_capacity = 16;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: miss after reset, extreme keys and values, update,
        // fill to capacity and evict the least recently used of the count-1 keys
        directed_rows.push_back('{OP_GET, 32'h0, 32'h0, 1, '{1'b0, 32'h0}});
        directed_rows.push_back('{OP_PUT, 32'h0, 32'hFFFF_FFFF, 1, '{1'b0, 32'h0}});
        directed_rows.push_back('{OP_PUT, 32'hFFFF_FFFF, 32'h0, 1, '{1'b0, 32'h0}});
        directed_rows.push_back('{OP_GET, 32'h0, 32'h0, 1, '{1'b1, 32'hFFFF_FFFF}});
        directed_rows.push_back('{OP_GET, 32'hFFFF_FFFF, 32'h0, 1, '{1'b1, 32'h0}});
        directed_rows.push_back('{OP_PUT, 32'h0, 32'h1234_5678, 1, '{1'b1, 32'h0}});
        directed_rows.push_back('{OP_GET, 32'h0, 32'hFFFF_FFFF, 1,
                                  '{1'b1, 32'h1234_5678}});
        directed_rows.push_back('{OP_GET, 32'h5555_AAAA, 32'h0, 1, '{1'b0, 32'h0}});
        for (int i = 0; i < 14; i++)
            directed_rows.push_back('{OP_PUT, 32'd10 + i, $urandom(), 0, none});
        directed_rows.push_back('{OP_PUT, 32'd100, 32'hA5A5_5A5A, 1, '{1'b0, 32'h0}});
        directed_rows.push_back('{OP_GET, 32'd10, 32'h0, 1, '{1'b0, 32'h0}});
        directed_rows.push_back('{OP_GET, 32'd11, 32'h0, 0, none});
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_access(row.cmd, row.k, row.v, row.typed, row.want);
        end

        // Random phases over a range of capacities; lowering to 5 leaves
        // the store over-full, 31 is clamped to the store size
        caps = '{5'd16, 5'd5, 5'd0, 5'd1, 5'd31, 5'd3, 5'd2, 5'd16};
        foreach (caps[p]) begin
            set_capacity(caps[p]);
            key_pool.delete();
            for (int i = 0; i < 2 * ((caps[p] > 16) ? 16 : caps[p]) + 3; i++)
                key_pool.push_back($urandom());
            quiet = (p == 6);
            if (p == 4)
                hold_req = 1'b1;
            n_items = 190;
            for (int i = 0; i < n_items; i++) begin
                cmd = 1'($urandom_range(1));
                if ($urandom_range(9) == 0)
                    k = $urandom();
                else
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                send_access(cmd, k, $urandom(), 0, none);
            end
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        // Drain
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending_replies.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
